FILE: design/rtas_pkg.sv
// Shared types, constants and codes for the reduction tree adder switch.
package rtas_pkg;

   localparam int QueueDepth = 16;
   localparam int MaxOut     = 32;
   localparam int EntryW     = 64;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 3;

   localparam logic [1:0] CMD_PUSH_LEFT  = 2'd0;
   localparam logic [1:0] CMD_PUSH_RIGHT = 2'd1;
   localparam logic [1:0] CMD_PUSH_LINK  = 2'd2;
   localparam logic [1:0] CMD_TICK       = 2'd3;

   localparam logic [1:0] DEST_PARENT = 2'd0;
   localparam logic [1:0] DEST_LINK   = 2'd1;
   localparam logic [1:0] DEST_MEMORY = 2'd2;

   localparam logic [2:0] MODE_ADD2    = 3'd0;
   localparam logic [2:0] MODE_ADD3    = 3'd1;
   localparam logic [2:0] MODE_SPLIT   = 3'd2;
   localparam logic [2:0] MODE_FORWARD = 3'd3;
   localparam logic [2:0] MODE_MERGE   = 3'd4;

   localparam logic [2:0] REG_ROUTE_MODE    = 3'd0;
   localparam logic [2:0] REG_COMBINE_OP    = 3'd1;
   localparam logic [2:0] REG_LEFT_ENABLED  = 3'd2;
   localparam logic [2:0] REG_RIGHT_ENABLED = 3'd3;
   localparam logic [2:0] REG_LINK_ENABLED  = 3'd4;
   localparam logic [2:0] REG_LINK_RECEIVES = 3'd5;
   localparam logic [2:0] REG_TO_MEMORY     = 3'd6;
   localparam logic [2:0] REG_LINK_ON_RIGHT = 3'd7;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  tag;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic [2:0] route_mode;
      logic       combine_op;
      logic       left_enabled;
      logic       right_enabled;
      logic       link_enabled;
      logic       link_receives;
      logic       to_memory;
      logic       link_on_right;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  destination;
      logic [31:0] result_value;
      logic [7:0]  result_tag;
      logic [11:0] result_row;
      logic [11:0] result_col;
      logic        last_of_tick;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] value;
      logic [7:0]  neuron_tag;
      logic [11:0] row_index;
      logic [11:0] col_index;
   } req_type;

endpackage

FILE: design/rtas_if.sv
// Valid/ready channel interfaces for requests and responses.
interface rtas_req_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic signed [31:0]    value;
   logic [7:0]            neuron_tag;
   logic [11:0]           row_index;
   logic [11:0]           col_index;
   modport source (output valid, command, value, neuron_tag, row_index, col_index,
                   input ready);
   modport sink   (input valid, command, value, neuron_tag, row_index, col_index,
                   output ready);
endinterface

interface rtas_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            destination;
   logic signed [31:0]    result_value;
   logic [7:0]            result_tag;
   logic [11:0]           result_row;
   logic [11:0]           result_col;
   logic                  last_of_tick;
   modport source (output valid, destination, result_value, result_tag, result_row,
                   result_col, last_of_tick, input ready);
   modport sink   (input valid, destination, result_value, result_tag, result_row,
                   result_col, last_of_tick, output ready);
endinterface

FILE: design/rtas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rtas_ram #(
   parameter int Width = 64,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: design/rtas_queue.sv
// Circular queue: RAM plus head pointer and fill count, head entry read ahead.
module rtas_queue #(
   parameter int Depth = rtas_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rtas_pkg::entry_type   push_data,
   input  logic                  pop,
   output logic                  nonempty,
   output rtas_pkg::entry_type   head_data
);
   localparam int AddrW = $clog2(Depth);
   localparam int FillW = $clog2(Depth + 1);

   logic [AddrW-1:0] head_ff, head_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [FillW:0]   wr_sum;
   logic             do_push;
   logic [rtas_pkg::EntryW-1:0] rd_raw;

   assign do_push  = push && (fill_ff != FillW'(Depth));
   assign wr_sum   = {1'b0, FillW'(head_ff)} + {1'b0, fill_ff};
   assign wr_addr  = (wr_sum >= (FillW+1)'(Depth)) ? AddrW'(wr_sum - (FillW+1)'(Depth))
                                                   : AddrW'(wr_sum);
   assign head_in  = pop ? ((head_ff == AddrW'(Depth - 1)) ? '0 : head_ff + 1'b1) : head_ff;
   assign fill_in  = fill_ff + FillW'(do_push) - FillW'(pop);
   // read address follows the next head so the registered read shows the new head
   assign rd_addr  = head_in;
   assign nonempty = fill_ff != '0;
   assign head_data = rtas_pkg::entry_type'(rd_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   rtas_ram #(.Width(rtas_pkg::EntryW), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_addr),
      .wr_data (rtas_pkg::EntryW'(push_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
endmodule

FILE: design/reduction_tree_adder_switch_core.sv
// Top level of the reduction tree adder switch node.
// A push beat is taken in IDLE. After a push the node passes through SETTLE before the next
// beat (the queue RAM's registered read must refresh the head). A tick is accepted in IDLE and
// decided in STEP; split mode with both inputs present emits its second beat from EMIT, and
// forward-both alternates STEP and the WAIT gap state between its beats (up to 32 beats).
// A decision waits while the output register still holds an unaccepted beat, so a stalled
// receiver holds the decision back.
module reduction_tree_adder_switch_core #(
   parameter int QUEUE_DEPTH = rtas_pkg::QueueDepth
) (
   input  logic                                clock,
   input  logic                                reset,
   rtas_req_if.sink                            req,
   rtas_rsp_if.source                          rsp,
   input  logic                                csr_write_enable,
   input  logic [rtas_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [rtas_pkg::CsrDataW-1:0]       csr_write_data
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETTLE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;
   localparam int         FillW     = $clog2(QUEUE_DEPTH + 1);

   rtas_pkg::cfg_type   cfg_ff, cfg_in;
   logic [2:0]          state_ff, state_in;
   logic [5:0]          count_ff, count_in;   // forward-mode beats emitted this tick
   logic                fwd_right_ff, fwd_right_in;
   rtas_pkg::rsp_type   out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic                lq_push, rq_push, fq_push;
   logic                lq_pop, rq_pop, fq_pop;
   logic                lq_ne, rq_ne, fq_ne;
   rtas_pkg::entry_type lq_head, rq_head, fq_head, push_entry;

   // pending second result of a split tick
   logic                pend_ff, pend_in;
   rtas_pkg::rsp_type   pend_data_ff, pend_data_in;

   // more entries remain after popping the head (fill above one)
   logic                lq_head_more, rq_head_more;
   logic [FillW-1:0]    lq_fill_ff, rq_fill_ff;

   logic                req_fire;
   logic [1:0]          par_dest;
   rtas_pkg::entry_type comb;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign push_entry.value = req.value;
   assign push_entry.tag   = req.neuron_tag;
   assign push_entry.row   = req.row_index;
   assign push_entry.col   = req.col_index;

   assign lq_push = req_fire && (req.command == rtas_pkg::CMD_PUSH_LEFT);
   assign rq_push = req_fire && (req.command == rtas_pkg::CMD_PUSH_RIGHT);
   assign fq_push = req_fire && (req.command == rtas_pkg::CMD_PUSH_LINK)
                    && cfg_ff.link_enabled && cfg_ff.link_receives;

   assign par_dest = cfg_ff.to_memory ? rtas_pkg::DEST_MEMORY : rtas_pkg::DEST_PARENT;

   always_comb begin
      comb.tag = lq_head.tag;
      comb.row = rq_head.row;
      comb.col = lq_head.col;
      if (cfg_ff.combine_op) begin
         comb.value = ($signed(lq_head.value) > $signed(rq_head.value)) ? lq_head.value
                                                                         : rq_head.value;
      end else begin
         comb.value = lq_head.value + rq_head.value;
      end
   end

   function automatic rtas_pkg::rsp_type mk(input logic [1:0] d, input rtas_pkg::entry_type e,
                                            input logic last);
      rtas_pkg::rsp_type r;
      r.destination  = d;
      r.result_value = e.value;
      r.result_tag   = e.tag;
      r.result_row   = e.row;
      r.result_col   = e.col;
      r.last_of_tick = last;
      return r;
   endfunction

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rtas_pkg::REG_ROUTE_MODE:    cfg_in.route_mode    = csr_write_data;
            rtas_pkg::REG_COMBINE_OP:    cfg_in.combine_op    = csr_write_data[0];
            rtas_pkg::REG_LEFT_ENABLED:  cfg_in.left_enabled  = csr_write_data[0];
            rtas_pkg::REG_RIGHT_ENABLED: cfg_in.right_enabled = csr_write_data[0];
            rtas_pkg::REG_LINK_ENABLED:  cfg_in.link_enabled  = csr_write_data[0];
            rtas_pkg::REG_LINK_RECEIVES: cfg_in.link_receives = csr_write_data[0];
            rtas_pkg::REG_TO_MEMORY:     cfg_in.to_memory     = csr_write_data[0];
            rtas_pkg::REG_LINK_ON_RIGHT: cfg_in.link_on_right = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [1:0]          rdest;
      rtas_pkg::entry_type e3;
      logic                more;
      rdest        = cfg_ff.link_enabled ? rtas_pkg::DEST_LINK : par_dest;
      e3           = '0;
      more         = 1'b0;
      state_in     = state_ff;
      count_in     = count_ff;
      fwd_right_in = fwd_right_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      lq_pop = 1'b0;
      rq_pop = 1'b0;
      fq_pop = 1'b0;
      if (rsp.valid && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in     = (req.command == rtas_pkg::CMD_TICK) ? ST_STEP : ST_SETTLE;
               count_in     = '0;
               fwd_right_in = 1'b0;
            end
         end
         ST_SETTLE: state_in = ST_IDLE;
         ST_STEP: begin
            // one decision per visit to STEP; output register must be free
            if (!out_valid_ff || (rsp.valid && rsp.ready)) begin
               state_in = ST_IDLE;
               unique case (cfg_ff.route_mode)
                  rtas_pkg::MODE_ADD2: begin
                     if (lq_ne && rq_ne) begin
                        lq_pop = 1'b1; rq_pop = 1'b1;
                        out_in = mk(rdest, comb, 1'b1); out_valid_in = 1'b1;
                     end else if (lq_ne && !cfg_ff.right_enabled) begin
                        lq_pop = 1'b1;
                        out_in = mk(rdest, lq_head, 1'b1); out_valid_in = 1'b1;
                     end else if (rq_ne && !cfg_ff.left_enabled) begin
                        rq_pop = 1'b1;
                        out_in = mk(rdest, rq_head, 1'b1); out_valid_in = 1'b1;
                     end
                  end
                  rtas_pkg::MODE_ADD3: begin
                     if (lq_ne && rq_ne && fq_ne) begin
                        lq_pop = 1'b1; rq_pop = 1'b1; fq_pop = 1'b1;
                        e3.value = lq_head.value + rq_head.value + fq_head.value;
                        e3.tag   = lq_head.tag;
                        out_in = mk(par_dest, e3, 1'b1); out_valid_in = 1'b1;
                     end
                  end
                  rtas_pkg::MODE_SPLIT: begin
                     lq_pop = lq_ne; rq_pop = rq_ne;
                     if (lq_ne && rq_ne) begin
                        // link-bound one first
                        if (cfg_ff.link_on_right) begin
                           out_in       = mk(rtas_pkg::DEST_LINK, rq_head, 1'b0);
                           pend_data_in = mk(par_dest, lq_head, 1'b1);
                        end else begin
                           out_in       = mk(rtas_pkg::DEST_LINK, lq_head, 1'b0);
                           pend_data_in = mk(par_dest, rq_head, 1'b1);
                        end
                        out_valid_in = 1'b1; pend_in = 1'b1; state_in = ST_EMIT;
                     end else if (lq_ne) begin
                        out_in = mk(cfg_ff.link_on_right ? par_dest : rtas_pkg::DEST_LINK,
                                    lq_head, 1'b1);
                        out_valid_in = 1'b1;
                     end else if (rq_ne) begin
                        out_in = mk(cfg_ff.link_on_right ? rtas_pkg::DEST_LINK : par_dest,
                                    rq_head, 1'b1);
                        out_valid_in = 1'b1;
                     end
                  end
                  rtas_pkg::MODE_FORWARD: begin
                     if (lq_ne && !fwd_right_ff) begin
                        lq_pop = 1'b1;
                        more = (count_ff != 6'(rtas_pkg::MaxOut - 1))
                               && (lq_head_more || rq_ne);
                        out_in = mk(par_dest, lq_head, !more); out_valid_in = 1'b1;
                        if (!lq_head_more) fwd_right_in = 1'b1;
                     end else if (rq_ne) begin
                        rq_pop = 1'b1;
                        more = (count_ff != 6'(rtas_pkg::MaxOut - 1)) && rq_head_more;
                        out_in = mk(par_dest, rq_head, !more); out_valid_in = 1'b1;
                        fwd_right_in = 1'b1;
                     end
                     count_in = count_ff + 1'b1;
                     if (more) state_in = ST_WAIT;
                  end
                  rtas_pkg::MODE_MERGE: begin
                     if (lq_ne && (!rq_ne || lq_head.col < rq_head.col)) begin
                        lq_pop = 1'b1;
                        out_in = mk(par_dest, lq_head, 1'b1); out_valid_in = 1'b1;
                     end else if (rq_ne && (!lq_ne || lq_head.col > rq_head.col)) begin
                        rq_pop = 1'b1;
                        out_in = mk(par_dest, rq_head, 1'b1); out_valid_in = 1'b1;
                     end else if (lq_ne && rq_ne) begin
                        lq_pop = 1'b1; rq_pop = 1'b1;
                        out_in = mk(par_dest, comb, 1'b1); out_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT: state_in = ST_STEP;   // gap state between forwarded beats
         ST_EMIT: begin
            if (!out_valid_ff || (rsp.valid && rsp.ready)) begin
               out_in = pend_data_ff; out_valid_in = 1'b1;
               pend_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign lq_head_more = lq_fill_ff > FillW'(1);
   assign rq_head_more = rq_fill_ff > FillW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         lq_fill_ff <= '0;
         rq_fill_ff <= '0;
      end else begin
         lq_fill_ff <= lq_fill_ff + FillW'(lq_push && lq_fill_ff != FillW'(QUEUE_DEPTH))
                       - FillW'(lq_pop);
         rq_fill_ff <= rq_fill_ff + FillW'(rq_push && rq_fill_ff != FillW'(QUEUE_DEPTH))
                       - FillW'(rq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fwd_right_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         fwd_right_ff <= fwd_right_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      out_ff       <= out_in;
      pend_data_ff <= pend_data_in;
   end

   rtas_queue #(.Depth(QUEUE_DEPTH)) u_left (
      .clock(clock), .reset(reset), .push(lq_push), .push_data(push_entry),
      .pop(lq_pop), .nonempty(lq_ne), .head_data(lq_head));
   rtas_queue #(.Depth(QUEUE_DEPTH)) u_right (
      .clock(clock), .reset(reset), .push(rq_push), .push_data(push_entry),
      .pop(rq_pop), .nonempty(rq_ne), .head_data(rq_head));
   rtas_queue #(.Depth(QUEUE_DEPTH)) u_link (
      .clock(clock), .reset(reset), .push(fq_push), .push_data(push_entry),
      .pop(fq_pop), .nonempty(fq_ne), .head_data(fq_head));

   assign rsp.valid        = out_valid_ff;
   assign rsp.destination  = out_ff.destination;
   assign rsp.result_value = out_ff.result_value;
   assign rsp.result_tag   = out_ff.result_tag;
   assign rsp.result_row   = out_ff.result_row;
   assign rsp.result_col   = out_ff.result_col;
   assign rsp.last_of_tick = out_ff.last_of_tick;

   a_pend_in_emit: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_EMIT)) else $error("split pending outside emit");
   a_no_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(lq_pop || rq_pop || fq_pop))
      else $error("queue pop while idle");
   a_fwd_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 6'(rtas_pkg::MaxOut)) else $error("forward burst too long");
endmodule
